>>> rtl/core/ll1pp_pkg.sv
// Package: symbol codes, result kinds, parse table and rule ROM functions.
`timescale 1ns / 1ps
`default_nettype none
package ll1pp_pkg;

    localparam int unsigned SYM_W      = 7;
    localparam int unsigned TOK_W      = 6;
    localparam int unsigned LINE_W     = 16;
    localparam int unsigned RULE_W     = 7;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned LEN_W      = 5;
    localparam int unsigned EXP_W      = 5;
    localparam logic [SYM_W-1:0] START_SYMBOL = 7'd51;
    localparam logic [RULE_W-1:0] MAX_RULE    = 7'd90;
    localparam logic [EXP_W-1:0]  EXP_CAP     = 5'd31;

    typedef enum logic [KIND_W-1:0] {
        KIND_EXPAND   = 3'd0,
        KIND_MATCH    = 3'd1,
        KIND_ERROR    = 3'd2,
        KIND_OVERFLOW = 3'd3,
        KIND_IGNORED  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DECIDE,
        ST_PUSH,
        ST_OUT
    } state_t;

    // Parse table: nonterminal and terminal to rule, zero where empty.
    function automatic logic [RULE_W-1:0] lookup(input logic [SYM_W-1:0] nt,
                                                 input logic [TOK_W-1:0] t);
        logic [RULE_W-1:0] r;
        r = '0;
        case ({nt, t})
            {7'd51,6'd2}: r=7'd1;
            {7'd52,6'd2}: r=7'd3; {7'd52,6'd3}: r=7'd3; {7'd52,6'd7}: r=7'd2;
            {7'd52,6'd13}: r=7'd3; {7'd52,6'd15}: r=7'd3; {7'd52,6'd19}: r=7'd3;
            {7'd52,6'd26}: r=7'd3;
            {7'd53,6'd2}: r=7'd13; {7'd53,6'd3}: r=7'd13; {7'd53,6'd13}: r=7'd13;
            {7'd53,6'd15}: r=7'd19; {7'd53,6'd19}: r=7'd13; {7'd53,6'd26}: r=7'd13;
            {7'd54,6'd15}: r=7'd31;
            {7'd55,6'd41}: r=7'd4; {7'd55,6'd43}: r=7'd5;
            {7'd56,6'd3}: r=7'd8; {7'd56,6'd13}: r=7'd6; {7'd56,6'd19}: r=7'd7;
            {7'd56,6'd26}: r=7'd9;
            {7'd57,6'd2}: r=7'd10; {7'd57,6'd3}: r=7'd10; {7'd57,6'd7}: r=7'd11;
            {7'd57,6'd13}: r=7'd10; {7'd57,6'd15}: r=7'd10; {7'd57,6'd19}: r=7'd10;
            {7'd57,6'd26}: r=7'd10;
            {7'd59,6'd7}: r=7'd12;
            {7'd60,6'd2}: r=7'd15; {7'd60,6'd3}: r=7'd18; {7'd60,6'd13}: r=7'd14;
            {7'd60,6'd19}: r=7'd17; {7'd60,6'd26}: r=7'd16;
            {7'd61,6'd39}: r=7'd26; {7'd61,6'd46}: r=7'd27;
            {7'd62,6'd5}: r=7'd20; {7'd62,6'd6}: r=7'd21; {7'd62,6'd8}: r=7'd23;
            {7'd62,6'd9}: r=7'd22; {7'd62,6'd10}: r=7'd24; {7'd62,6'd45}: r=7'd25;
            {7'd63,6'd3}: r=7'd28; {7'd63,6'd13}: r=7'd28; {7'd63,6'd19}: r=7'd28;
            {7'd63,6'd26}: r=7'd28;
            {7'd64,6'd40}: r=7'd29; {7'd64,6'd45}: r=7'd30;
            {7'd65,6'd1}: r=7'd52; {7'd65,6'd7}: r=7'd34; {7'd65,6'd8}: r=7'd36;
            {7'd65,6'd10}: r=7'd35; {7'd65,6'd16}: r=7'd49; {7'd65,6'd18}: r=7'd64;
            {7'd65,6'd23}: r=7'd67; {7'd65,6'd24}: r=7'd69; {7'd65,6'd25}: r=7'd68;
            {7'd65,6'd27}: r=7'd39; {7'd65,6'd40}: r=7'd38;
            {7'd66,6'd1}: r=7'd33; {7'd66,6'd7}: r=7'd33; {7'd66,6'd8}: r=7'd33;
            {7'd66,6'd10}: r=7'd33; {7'd66,6'd16}: r=7'd33; {7'd66,6'd18}: r=7'd33;
            {7'd66,6'd20}: r=7'd32; {7'd66,6'd23}: r=7'd33; {7'd66,6'd24}: r=7'd33;
            {7'd66,6'd25}: r=7'd33; {7'd66,6'd27}: r=7'd33; {7'd66,6'd38}: r=7'd32;
            {7'd66,6'd40}: r=7'd33;
            {7'd67,6'd5}: r=7'd75; {7'd67,6'd6}: r=7'd75; {7'd67,6'd7}: r=7'd75;
            {7'd67,6'd8}: r=7'd75; {7'd67,6'd10}: r=7'd75; {7'd67,6'd27}: r=7'd76;
            {7'd67,6'd46}: r=7'd75;
            {7'd68,6'd40}: r=7'd40; {7'd68,6'd45}: r=7'd40; {7'd68,6'd46}: r=7'd41;
            {7'd69,6'd5}: r=7'd44; {7'd69,6'd6}: r=7'd46; {7'd69,6'd7}: r=7'd48;
            {7'd69,6'd8}: r=7'd47; {7'd69,6'd10}: r=7'd45;
            {7'd70,6'd43}: r=7'd43; {7'd70,6'd45}: r=7'd42;
            {7'd71,6'd29}: r=7'd56; {7'd71,6'd30}: r=7'd55; {7'd71,6'd31}: r=7'd53;
            {7'd71,6'd33}: r=7'd58; {7'd71,6'd35}: r=7'd57; {7'd71,6'd48}: r=7'd54;
            {7'd72,6'd21}: r=7'd50; {7'd72,6'd40}: r=7'd51;
            {7'd73,6'd5}: r=7'd59; {7'd73,6'd6}: r=7'd60; {7'd73,6'd7}: r=7'd63;
            {7'd73,6'd8}: r=7'd62; {7'd73,6'd10}: r=7'd61;
            {7'd74,6'd36}: r=7'd65; {7'd74,6'd49}: r=7'd66;
            {7'd75,6'd34}: r=7'd90; {7'd75,6'd40}: r=7'd70;
            {7'd76,6'd34}: r=7'd73; {7'd76,6'd40}: r=7'd73; {7'd76,6'd43}: r=7'd74;
            {7'd79,6'd5}: r=7'd80; {7'd79,6'd6}: r=7'd80; {7'd79,6'd7}: r=7'd80;
            {7'd79,6'd8}: r=7'd80; {7'd79,6'd10}: r=7'd80; {7'd79,6'd46}: r=7'd80;
            {7'd80,6'd37}: r=7'd77; {7'd80,6'd40}: r=7'd79; {7'd80,6'd45}: r=7'd79;
            {7'd80,6'd50}: r=7'd78;
            {7'd81,6'd5}: r=7'd84; {7'd81,6'd6}: r=7'd85; {7'd81,6'd7}: r=7'd86;
            {7'd81,6'd8}: r=7'd88; {7'd81,6'd10}: r=7'd87; {7'd81,6'd46}: r=7'd89;
            {7'd82,6'd37}: r=7'd81; {7'd82,6'd40}: r=7'd81; {7'd82,6'd42}: r=7'd83;
            {7'd82,6'd44}: r=7'd82; {7'd82,6'd45}: r=7'd81; {7'd82,6'd50}: r=7'd81;
            {7'd83,6'd7}: r=7'd71; {7'd83,6'd12}: r=7'd72;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Right-hand side packed as 16 symbols, leftmost in the lowest slot.
    function automatic logic [16*SYM_W-1:0] rhs_syms(input logic [RULE_W-1:0] rule);
        logic [SYM_W-1:0] s [16];
        logic [16*SYM_W-1:0] p;
        for (int i = 0; i < 16; i++)
            s[i] = '0;
        case (rule)
            7'd1:  begin s[0]=2; s[1]=11; s[2]=39; s[3]=52; s[4]=53; s[5]=54; s[6]=38; end
            7'd2:  begin s[0]=7; s[1]=55; s[2]=41; s[3]=56; s[4]=40; s[5]=57; end
            7'd5:  begin s[0]=43; s[1]=7; s[2]=55; end
            7'd6, 7'd14: s[0]=13;
            7'd7, 7'd17: s[0]=19;
            7'd8, 7'd18: s[0]=3;
            7'd9, 7'd16: s[0]=26;
            7'd11: begin s[0]=59; s[1]=41; s[2]=56; s[3]=40; s[4]=57; end
            7'd12: begin s[0]=7; s[1]=55; end
            7'd13: begin s[0]=60; s[1]=7; s[2]=61; s[3]=39; s[4]=52; s[5]=53; s[6]=54;
                         s[7]=4; s[8]=46; s[9]=62; s[10]=45; s[11]=38; s[12]=53; end
            7'd15: s[0]=2;
            7'd20, 7'd44, 7'd59, 7'd84: s[0]=5;
            7'd21, 7'd46, 7'd60, 7'd85: s[0]=6;
            7'd22: s[0]=9;
            7'd23, 7'd47, 7'd62, 7'd88: s[0]=8;
            7'd24, 7'd45, 7'd61, 7'd87: s[0]=10;
            7'd48, 7'd63, 7'd86: s[0]=7;
            7'd27: begin s[0]=46; s[1]=63; s[2]=45; end
            7'd28: begin s[0]=56; s[1]=64; end
            7'd29: begin s[0]=40; s[1]=56; s[2]=64; end
            7'd31: begin s[0]=15; s[1]=65; s[2]=40; s[3]=66; s[4]=20; end
            7'd33: begin s[0]=65; s[1]=40; s[2]=66; end
            7'd34: begin s[0]=7; s[1]=32; s[2]=67; end
            7'd35: begin s[0]=10; s[1]=32; s[2]=67; end
            7'd36: begin s[0]=8; s[1]=32; s[2]=67; end
            7'd37: begin s[0]=67; s[1]=32; s[2]=67; end
            7'd39, 7'd76: begin s[0]=27; s[1]=7; s[2]=68; end
            7'd41: begin s[0]=46; s[1]=69; s[2]=70; s[3]=45; end
            7'd43: begin s[0]=43; s[1]=69; s[2]=70; end
            7'd49: begin s[0]=16; s[1]=46; s[2]=7; s[3]=71; s[4]=45; s[5]=39; s[6]=65;
                         s[7]=40; s[8]=66; s[9]=38; s[10]=72; end
            7'd50: begin s[0]=21; s[1]=39; s[2]=65; s[3]=40; s[4]=66; s[5]=38; end
            7'd52: begin s[0]=1; s[1]=46; s[2]=7; s[3]=71; s[4]=45; s[5]=39; s[6]=65;
                         s[7]=40; s[8]=66; s[9]=38; end
            7'd53: begin s[0]=31; s[1]=73; end
            7'd54: begin s[0]=48; s[1]=73; end
            7'd55: begin s[0]=30; s[1]=73; end
            7'd56: begin s[0]=29; s[1]=73; end
            7'd57: begin s[0]=35; s[1]=73; end
            7'd58: begin s[0]=33; s[1]=73; end
            7'd64: begin s[0]=18; s[1]=46; s[2]=7; s[3]=32; s[4]=73; s[5]=40; s[6]=7;
                         s[7]=71; s[8]=40; s[9]=74; s[10]=45; s[11]=39; s[12]=65;
                         s[13]=40; s[14]=66; s[15]=38; end
            7'd65: begin s[0]=36; s[1]=5; end
            7'd66: begin s[0]=49; s[1]=5; end
            7'd67: begin s[0]=23; s[1]=39; s[2]=65; s[3]=40; s[4]=66; s[5]=38; s[6]=1;
                         s[7]=46; s[8]=7; s[9]=71; s[10]=45; end
            7'd68: begin s[0]=25; s[1]=28; s[2]=7; end
            7'd69: begin s[0]=24; s[1]=34; s[2]=12; s[3]=75; end
            7'd71: begin s[0]=7; s[1]=76; s[2]=75; end
            7'd72: begin s[0]=12; s[1]=75; end
            7'd74: begin s[0]=43; s[1]=7; s[2]=76; end
            7'd75: begin s[0]=79; s[1]=80; end
            7'd77: begin s[0]=37; s[1]=79; s[2]=80; end
            7'd78: begin s[0]=50; s[1]=79; s[2]=80; end
            7'd80: begin s[0]=81; s[1]=82; end
            7'd82: begin s[0]=44; s[1]=81; s[2]=82; end
            7'd83: begin s[0]=42; s[1]=81; s[2]=82; end
            7'd89: begin s[0]=46; s[1]=67; s[2]=45; end
            7'd90: begin s[0]=34; s[1]=83; end
            default: ;
        endcase
        for (int i = 0; i < 16; i++)
            p[i*SYM_W +: SYM_W] = s[i];
        return p;
    endfunction

    function automatic logic [LEN_W-1:0] rhs_len(input logic [RULE_W-1:0] rule);
        logic [LEN_W-1:0] n;
        case (rule)
            7'd1: n = 5'd7;
            7'd2, 7'd50: n = 5'd6;
            7'd11, 7'd31: n = 5'd5;
            7'd13: n = 5'd13;
            7'd41, 7'd69: n = 5'd4;
            7'd49, 7'd67: n = 5'd11;
            7'd52: n = 5'd10;
            7'd64: n = 5'd16;
            7'd12, 7'd28, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57, 7'd58, 7'd65, 7'd66,
            7'd72, 7'd75, 7'd80, 7'd90: n = 5'd2;
            7'd5, 7'd27, 7'd29, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37, 7'd39, 7'd43,
            7'd68, 7'd71, 7'd74, 7'd76, 7'd77, 7'd78, 7'd82, 7'd83, 7'd89: n = 5'd3;
            7'd6, 7'd7, 7'd8, 7'd9, 7'd14, 7'd15, 7'd16, 7'd17, 7'd18, 7'd20, 7'd21,
            7'd22, 7'd23, 7'd24, 7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd59, 7'd60,
            7'd61, 7'd62, 7'd63, 7'd84, 7'd85, 7'd86, 7'd87, 7'd88: n = 5'd1;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/ll1pp_if.sv
// Interfaces: token input channel and parse result channel.
`timescale 1ns / 1ps
`default_nettype none
interface ll1pp_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_id;
    logic [15:0] line_number;
    logic        restart;
    modport source (output valid, token_id, line_number, restart, input ready);
    modport sink   (input valid, token_id, line_number, restart, output ready);
endinterface

interface ll1pp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [6:0]  rule_number;
    logic [6:0]  stack_top_symbol;
    logic [15:0] error_line;
    logic        last;
    modport source (output valid, kind, rule_number, stack_top_symbol, error_line, last,
                    input ready);
    modport sink   (input valid, kind, rule_number, stack_top_symbol, error_line, last,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/core/ll1pp_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ll1pp_ram #(
    parameter int unsigned WIDTH = 7,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/ll1_predictive_parser_unit.sv
// Top level: LL(1) predictive parser with the symbol stack in a RAM.
//
//  channel | dir | payload                                              | transfer
//  tok     | in  | token_id, line_number, restart                       | valid & ready
//  res     | out | kind, rule_number, stack_top_symbol, error_line, last | valid & ready
//
// Each stack action passes the read and decide states, using the stack RAM's one
// read port; an expansion then pushes one symbol a cycle from its right-hand side.
// Results are handed off between actions; a token that finds the parser halted,
// or the stack empty without restart, skips read and decide and goes to its handoff.
// Reset leaves the start symbol as the only stack entry (held in a register
// for slot zero). A stalled result holds the sequencer; no token is taken
// until the last result of the previous one has been transferred.
`timescale 1ns / 1ps
`default_nettype none
module ll1_predictive_parser_unit #(
    parameter int unsigned STACK_DEPTH    = 64,
    parameter int unsigned MAX_EXPANSIONS = 31
) (
    input wire logic     clk,
    input wire logic     rst_n,
    ll1pp_tok_if.sink    tok,
    ll1pp_res_if.source  res
);
    localparam int unsigned AW  = $clog2(STACK_DEPTH);
    localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned LIM = (MAX_EXPANSIONS < 31) ? MAX_EXPANSIONS : 31;
    localparam logic [ll1pp_pkg::EXP_W-1:0] EXP_LIMIT = ll1pp_pkg::EXP_W'(LIM);

    ll1pp_pkg::state_t state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic                           halted_reg, halted_next;
    logic [ll1pp_pkg::EXP_W-1:0]    exp_reg, exp_next;
    logic [ll1pp_pkg::TOK_W-1:0]    tok_reg;
    logic [ll1pp_pkg::LINE_W-1:0]   line_reg;
    logic [ll1pp_pkg::RULE_W-1:0]   rule_reg, rule_next;
    logic [ll1pp_pkg::LEN_W-1:0]    idx_reg, idx_next;
    logic                           done_reg, done_next;
    logic [ll1pp_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [ll1pp_pkg::RULE_W-1:0]   orule_reg, orule_next;
    logic [ll1pp_pkg::SYM_W-1:0]    otop_reg, otop_next;

    logic                           we;
    logic [AW-1:0]                  waddr, raddr;
    logic [ll1pp_pkg::SYM_W-1:0]    wdata, rdata, top;
    logic [ll1pp_pkg::RULE_W-1:0]   look;
    logic [ll1pp_pkg::LEN_W-1:0]    len;
    logic [16*ll1pp_pkg::SYM_W-1:0] syms;
    logic [CW:0]                    need;

    ll1pp_ram #(.WIDTH(ll1pp_pkg::SYM_W), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // Slot zero after reset or restart holds the start symbol until overwritten.
    logic seed_reg, seed_next;
    assign top  = (seed_reg && count_reg == CW'(1)) ? ll1pp_pkg::START_SYMBOL : rdata;
    assign look = ll1pp_pkg::lookup(top, tok_reg);
    assign len  = ll1pp_pkg::rhs_len(look);
    assign syms = ll1pp_pkg::rhs_syms(rule_reg);
    assign need = (CW+1)'(count_reg) - (CW+1)'(1) + (CW+1)'(len);
    assign raddr = AW'(count_reg - CW'(1));
    assign tok.ready = (state_reg == ll1pp_pkg::ST_IDLE);

    always_comb
    begin
        we = 1'b0;
        waddr = AW'(count_reg);
        wdata = syms[idx_reg*ll1pp_pkg::SYM_W +: ll1pp_pkg::SYM_W];
        if (state_reg == ll1pp_pkg::ST_PUSH)
            we = 1'b1;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        halted_next = halted_reg;
        exp_next    = exp_reg;
        rule_next   = rule_reg;
        idx_next    = idx_reg;
        done_next   = done_reg;
        kind_next   = kind_reg;
        orule_next  = orule_reg;
        otop_next   = otop_reg;
        seed_next   = seed_reg;
        unique case (state_reg)
            ll1pp_pkg::ST_IDLE:
            begin
                if (tok.valid)
                begin
                    exp_next = '0;
                    if (tok.restart)
                    begin
                        count_next  = CW'(1);
                        halted_next = 1'b0;
                        seed_next   = 1'b1;
                    end
                    if ((halted_reg && !tok.restart) || (count_reg == '0 && !tok.restart))
                    begin
                        kind_next  = ll1pp_pkg::KIND_IGNORED;
                        orule_next = '0;
                        otop_next  = '0;
                        done_next  = 1'b1;
                        state_next = ll1pp_pkg::ST_OUT;
                    end
                    else
                        state_next = ll1pp_pkg::ST_READ;
                end
            end
            ll1pp_pkg::ST_READ:
            begin
                if (count_reg == '0)
                begin
                    kind_next  = ll1pp_pkg::KIND_IGNORED;
                    orule_next = '0;
                    otop_next  = '0;
                    done_next  = 1'b1;
                    state_next = ll1pp_pkg::ST_OUT;
                end
                else
                    state_next = ll1pp_pkg::ST_DECIDE;
            end
            ll1pp_pkg::ST_DECIDE:
            begin
                otop_next  = top;
                orule_next = '0;
                done_next  = 1'b1;
                state_next = ll1pp_pkg::ST_OUT;
                if (top == {1'b0, tok_reg})
                begin
                    kind_next  = ll1pp_pkg::KIND_MATCH;
                    count_next = count_reg - CW'(1);
                end
                else if (exp_reg >= EXP_LIMIT || look == '0 || look > ll1pp_pkg::MAX_RULE)
                begin
                    kind_next   = ll1pp_pkg::KIND_ERROR;
                    halted_next = 1'b1;
                end
                else if (need > (CW+1)'(STACK_DEPTH))
                begin
                    kind_next   = ll1pp_pkg::KIND_OVERFLOW;
                    halted_next = 1'b1;
                end
                else
                begin
                    kind_next  = ll1pp_pkg::KIND_EXPAND;
                    orule_next = look;
                    rule_next  = look;
                    done_next  = 1'b0;
                    count_next = count_reg - CW'(1);
                    exp_next   = exp_reg + 1'b1;
                    if (len == '0)
                        state_next = ll1pp_pkg::ST_OUT;
                    else
                    begin
                        idx_next   = len - 1'b1;
                        state_next = ll1pp_pkg::ST_PUSH;
                    end
                end
            end
            ll1pp_pkg::ST_PUSH:
            begin
                // Push rightmost first so the leftmost ends on top.
                if (count_reg == '0)
                    seed_next = 1'b0;
                count_next = count_reg + CW'(1);
                if (idx_reg == '0)
                    state_next = ll1pp_pkg::ST_OUT;
                else
                    idx_next = idx_reg - 1'b1;
            end
            ll1pp_pkg::ST_OUT:
            begin
                if (res.ready)
                    state_next = done_reg ? ll1pp_pkg::ST_IDLE : ll1pp_pkg::ST_READ;
            end
            default: state_next = ll1pp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ll1pp_pkg::ST_IDLE;
            count_reg  <= CW'(1);
            halted_reg <= 1'b0;
            seed_reg   <= 1'b1;
            done_reg   <= 1'b0;
            exp_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
            seed_reg   <= seed_next;
            done_reg   <= done_next;
            exp_reg    <= exp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ll1pp_pkg::ST_IDLE && tok.valid)
        begin
            tok_reg  <= tok.token_id;
            line_reg <= tok.line_number;
        end
        rule_reg  <= rule_next;
        idx_reg   <= idx_next;
        kind_reg  <= kind_next;
        orule_reg <= orule_next;
        otop_reg  <= otop_next;
    end

    assign res.valid            = (state_reg == ll1pp_pkg::ST_OUT);
    assign res.kind             = kind_reg;
    assign res.rule_number      = orule_reg;
    assign res.stack_top_symbol = otop_reg;
    assign res.error_line       = line_reg;
    assign res.last             = done_reg;
endmodule
`default_nettype wire

>>> rtl/core/ll1pp_checker.sv
// Checker: port-level properties of the parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ll1pp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       tok_valid,
    input wire logic       tok_ready,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [2:0] kind,
    input wire logic [6:0] rule_number,
    input wire logic       last
);
    a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !tok_ready) else $error("token taken while result pending");
    a_rule_only_expand: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind != ll1pp_pkg::KIND_EXPAND |-> rule_number == 7'd0)
        else $error("rule number on non-expansion result");
    a_expand_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == ll1pp_pkg::KIND_EXPAND |-> !last)
        else $error("expansion marked last");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(kind))
        else $error("stalled result changed");
    a_take_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_ready |=> !tok_ready) else $error("ready after transfer");
endmodule

bind ll1_predictive_parser_unit ll1pp_checker u_checker (
    .clk(clk), .rst_n(rst_n), .tok_valid(tok.valid), .tok_ready(tok.ready),
    .res_valid(res.valid), .res_ready(res.ready), .kind(res.kind),
    .rule_number(res.rule_number), .last(res.last)
);
`default_nettype wire

>>> sim/tb_top.sv
// Testbench for the LL(1) predictive parser: directed table plus random token streams.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    typedef struct packed {
        logic [2:0]  kind;
        logic [6:0]  rule;
        logic [6:0]  top;
        logic [15:0] line;
        logic        last;
    } parse_res_t;

    typedef struct packed {
        logic [5:0]  tok;
        logic [15:0] line;
        logic        restart;
        logic        has_exp;
        logic [2:0]  exp_kind;
        logic [6:0]  exp_top;
    } tok_row_t;

    localparam int DEPTH = 64;
    localparam int EXP_LIMIT = 31;
    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ll1pp_tok_if tok ();
    ll1pp_res_if res ();

    ll1_predictive_parser_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .tok   (tok.sink),
        .res   (res.source)
    );

    // predictor state
    logic [6:0] sym_stack [DEPTH];
    int         sym_count;
    bit         parse_halted;
    parse_res_t pending_results [$];
    int         errors = 0;
    int         idle_cycles = 0;
    bit         rx_hold = 1'b0;
    bit         stim_done = 1'b0;

    // rule table, rebuilt from the grammar: nonterminal, terminal, rule
    int          rule_of [int];
    int          rhs_len_of [int];
    logic [6:0]  rhs_of [int][$];

    function automatic void add_rule(int r, int syms []);
        rhs_len_of[r] = syms.size();
        rhs_of[r] = {};
        foreach (syms[i])
            rhs_of[r].insert(rhs_of[r].size(), 7'(syms[i]));
    endfunction

    function automatic void add_entries(int nt, int toks [], int rules []);
        foreach (toks[i])
            rule_of[nt * 64 + toks[i]] = rules[i];
    endfunction

    initial
    begin
        add_entries(51, '{2}, '{1});
        add_entries(52, '{2,3,7,13,15,19,26}, '{3,3,2,3,3,3,3});
        add_entries(53, '{2,3,13,15,19,26}, '{13,13,13,19,13,13});
        add_entries(54, '{15}, '{31});
        add_entries(55, '{41,43}, '{4,5});
        add_entries(56, '{3,13,19,26}, '{8,6,7,9});
        add_entries(57, '{2,3,7,13,15,19,26}, '{10,10,11,10,10,10,10});
        add_entries(59, '{7}, '{12});
        add_entries(60, '{2,3,13,19,26}, '{15,18,14,17,16});
        add_entries(61, '{39,46}, '{26,27});
        add_entries(62, '{5,6,8,9,10,45}, '{20,21,23,22,24,25});
        add_entries(63, '{3,13,19,26}, '{28,28,28,28});
        add_entries(64, '{40,45}, '{29,30});
        add_entries(65, '{1,7,8,10,16,18,23,24,25,27,40},
                    '{52,34,36,35,49,64,67,69,68,39,38});
        add_entries(66, '{1,7,8,10,16,18,20,23,24,25,27,38,40},
                    '{33,33,33,33,33,33,32,33,33,33,33,32,33});
        add_entries(67, '{5,6,7,8,10,27,46}, '{75,75,75,75,75,76,75});
        add_entries(68, '{40,45,46}, '{40,40,41});
        add_entries(69, '{5,6,7,8,10}, '{44,46,48,47,45});
        add_entries(70, '{43,45}, '{43,42});
        add_entries(71, '{29,30,31,33,35,48}, '{56,55,53,58,57,54});
        add_entries(72, '{21,40}, '{50,51});
        add_entries(73, '{5,6,7,8,10}, '{59,60,63,62,61});
        add_entries(74, '{36,49}, '{65,66});
        add_entries(75, '{34,40}, '{90,70});
        add_entries(76, '{34,40,43}, '{73,73,74});
        add_entries(79, '{5,6,7,8,10,46}, '{80,80,80,80,80,80});
        add_entries(80, '{37,40,45,50}, '{77,79,79,78});
        add_entries(81, '{5,6,7,8,10,46}, '{84,85,86,88,87,89});
        add_entries(82, '{37,40,42,44,45,50}, '{81,81,83,82,81,81});
        add_entries(83, '{7,12}, '{71,72});
        add_rule(1, '{2,11,39,52,53,54,38});
        add_rule(2, '{7,55,41,56,40,57});
        add_rule(5, '{43,7,55});
        add_rule(6, '{13}); add_rule(7, '{19}); add_rule(8, '{3}); add_rule(9, '{26});
        add_rule(11, '{59,41,56,40,57});
        add_rule(12, '{7,55});
        add_rule(13, '{60,7,61,39,52,53,54,4,46,62,45,38,53});
        add_rule(14, '{13}); add_rule(15, '{2}); add_rule(16, '{26});
        add_rule(17, '{19}); add_rule(18, '{3});
        add_rule(20, '{5}); add_rule(21, '{6}); add_rule(22, '{9});
        add_rule(23, '{8}); add_rule(24, '{10});
        add_rule(27, '{46,63,45});
        add_rule(28, '{56,64});
        add_rule(29, '{40,56,64});
        add_rule(31, '{15,65,40,66,20});
        add_rule(33, '{65,40,66});
        add_rule(34, '{7,32,67}); add_rule(35, '{10,32,67}); add_rule(36, '{8,32,67});
        add_rule(37, '{67,32,67});
        add_rule(39, '{27,7,68});
        add_rule(41, '{46,69,70,45});
        add_rule(43, '{43,69,70});
        add_rule(44, '{5}); add_rule(45, '{10}); add_rule(46, '{6});
        add_rule(47, '{8}); add_rule(48, '{7});
        add_rule(49, '{16,46,7,71,45,39,65,40,66,38,72});
        add_rule(50, '{21,39,65,40,66,38});
        add_rule(52, '{1,46,7,71,45,39,65,40,66,38});
        add_rule(53, '{31,73}); add_rule(54, '{48,73}); add_rule(55, '{30,73});
        add_rule(56, '{29,73}); add_rule(57, '{35,73}); add_rule(58, '{33,73});
        add_rule(59, '{5}); add_rule(60, '{6}); add_rule(61, '{10});
        add_rule(62, '{8}); add_rule(63, '{7});
        add_rule(64, '{18,46,7,32,73,40,7,71,40,74,45,39,65,40,66,38});
        add_rule(65, '{36,5}); add_rule(66, '{49,5});
        add_rule(67, '{23,39,65,40,66,38,1,46,7,71,45});
        add_rule(68, '{25,28,7});
        add_rule(69, '{24,34,12,75});
        add_rule(71, '{7,76,75});
        add_rule(72, '{12,75});
        add_rule(74, '{43,7,76});
        add_rule(75, '{79,80});
        add_rule(76, '{27,7,68});
        add_rule(77, '{37,79,80}); add_rule(78, '{50,79,80});
        add_rule(80, '{81,82});
        add_rule(82, '{44,81,82}); add_rule(83, '{42,81,82});
        add_rule(84, '{5}); add_rule(85, '{6}); add_rule(86, '{7});
        add_rule(87, '{10}); add_rule(88, '{8});
        add_rule(89, '{46,67,45});
        add_rule(90, '{34,83});
    end

    function automatic void push_result(ll1pp_pkg::kind_t k, int rule, int top,
                                        logic [15:0] line);
        parse_res_t r;
        r.kind = k;
        r.rule = rule[6:0];
        r.top  = top[6:0];
        r.line = line;
        r.last = 1'b0;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Advance the parse state by one token and queue the results it causes.
    function automatic void parse_token(logic [5:0] t, logic [15:0] line, logic rst);
        int expansions;
        int top;
        int rule;
        int len;
        parse_res_t r;
        expansions = 0;
        if (rst)
        begin
            sym_stack[0] = ll1pp_pkg::START_SYMBOL;
            sym_count = 1;
            parse_halted = 1'b0;
        end
        if (parse_halted || sym_count == 0)
            push_result(ll1pp_pkg::KIND_IGNORED, 0, 0, line);
        else
            forever
            begin
                if (sym_count == 0)
                begin
                    push_result(ll1pp_pkg::KIND_IGNORED, 0, 0, line);
                    break;
                end
                top = sym_stack[sym_count - 1];
                if (top == int'(t))
                begin
                    sym_count--;
                    push_result(ll1pp_pkg::KIND_MATCH, 0, top, line);
                    break;
                end
                rule = rule_of.exists(top * 64 + t) ? rule_of[top * 64 + t] : 0;
                if (expansions >= EXP_LIMIT || rule == 0)
                begin
                    push_result(ll1pp_pkg::KIND_ERROR, 0, top, line);
                    parse_halted = 1'b1;
                    break;
                end
                len = rhs_len_of.exists(rule) ? rhs_len_of[rule] : 0;
                if (sym_count - 1 + len > DEPTH)
                begin
                    push_result(ll1pp_pkg::KIND_OVERFLOW, 0, top, line);
                    parse_halted = 1'b1;
                    break;
                end
                sym_count--;
                for (int i = len - 1; i >= 0; i--)
                begin
                    sym_stack[sym_count] = rhs_of[rule][i];
                    sym_count++;
                end
                push_result(ll1pp_pkg::KIND_EXPAND, rule, top, line);
                expansions++;
            end
        r = pending_results[pending_results.size() - 1];
        r.last = 1'b1;
        pending_results[pending_results.size() - 1] = r;
    endfunction

    // Sender: valid stays high into the next token when there is no gap
    task automatic send_token(logic [5:0] t, logic [15:0] line, logic rst);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            tok.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tok.valid       <= 1'b1;
        tok.token_id    <= t;
        tok.line_number <= line;
        tok.restart     <= rst;
        @(posedge clk);
        while (!tok.ready)
            @(posedge clk);
        parse_token(t, line, rst);
    endtask

    task automatic wait_drained();
        tok.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Pick a token that the current top can accept, so the parse goes deep.
    function automatic logic [5:0] good_token();
        int top;
        int cands [$];
        if (parse_halted || sym_count == 0)
            return 6'($urandom_range(1, 50));
        top = sym_stack[sym_count - 1];
        if (top <= 50)
            return 6'(top);
        for (int t = 1; t <= 50; t++)
            if (rule_of.exists(top * 64 + t))
                cands.insert(cands.size(), t);
        if (cands.size() == 0)
            return 6'($urandom_range(1, 50));
        return 6'(cands[$urandom_range(0, cands.size() - 1)]);
    endfunction

    tok_row_t directed [] = '{
        '{6'd2,  16'hFFFF, 1'b0, 1'b1, ll1pp_pkg::KIND_MATCH, 7'd2},
        '{6'd11, 16'h1234, 1'b0, 1'b0, ll1pp_pkg::KIND_MATCH, 7'd0},
        '{6'd39, 16'h0001, 1'b0, 1'b0, ll1pp_pkg::KIND_MATCH, 7'd0},
        '{6'd7,  16'h8000, 1'b0, 1'b0, ll1pp_pkg::KIND_EXPAND, 7'd0},
        '{6'd50, 16'h5555, 1'b0, 1'b1, ll1pp_pkg::KIND_ERROR, 7'd55},
        '{6'd7,  16'hAAAA, 1'b0, 1'b1, ll1pp_pkg::KIND_IGNORED, 7'd0},
        '{6'd1,  16'h0002, 1'b1, 1'b1, ll1pp_pkg::KIND_ERROR, 7'd51},
        '{6'd51, 16'h0003, 1'b1, 1'b1, ll1pp_pkg::KIND_MATCH, 7'd51},
        '{6'd5,  16'h0004, 1'b0, 1'b1, ll1pp_pkg::KIND_IGNORED, 7'd0},
        '{6'd63, 16'h0005, 1'b1, 1'b1, ll1pp_pkg::KIND_ERROR, 7'd51},
        '{6'd0,  16'h0006, 1'b1, 1'b1, ll1pp_pkg::KIND_ERROR, 7'd51},
        '{6'd2,  16'h0007, 1'b1, 1'b0, ll1pp_pkg::KIND_EXPAND, 7'd0},
        '{6'd2,  16'h0008, 1'b0, 1'b0, ll1pp_pkg::KIND_EXPAND, 7'd0},
        '{6'd11, 16'h0009, 1'b0, 1'b0, ll1pp_pkg::KIND_EXPAND, 7'd0},
        '{6'd39, 16'h000A, 1'b0, 1'b0, ll1pp_pkg::KIND_EXPAND, 7'd0},
        '{6'd15, 16'h000B, 1'b0, 1'b0, ll1pp_pkg::KIND_EXPAND, 7'd0},
        '{6'd18, 16'h000C, 1'b0, 1'b0, ll1pp_pkg::KIND_EXPAND, 7'd0}
    };

    initial
    begin
        logic [5:0] t;
        int seq_len;
        tok.valid = 1'b0;
        tok.token_id = '0;
        tok.line_number = '0;
        tok.restart = 1'b0;
        sym_stack[0] = ll1pp_pkg::START_SYMBOL;
        sym_count = 1;
        parse_halted = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
        begin
            send_token(directed[i].tok, directed[i].line, directed[i].restart);
            if (directed[i].has_exp)
            begin
                // directed expectation is the final result of the row
                parse_res_t r;
                r = pending_results[$];
                if (r.kind != directed[i].exp_kind || r.top != directed[i].exp_top)
                begin
                    $display("%0t: row %0d expected kind %0d top %0d, predicted %0d %0d",
                             $time, i, directed[i].exp_kind, directed[i].exp_top,
                             r.kind, r.top);
                    errors++;
                end
            end
        end
        // pause until everything has drained
        wait_drained();
        // push deep: exhaust the stack by repeating 18 under nonterminal 65 trails
        for (int n = 0; n < 250; n++)
        begin
            if (n % 40 == 0 || $urandom_range(0, 15) == 0)
            begin
                send_token(6'd2, 16'($urandom), 1'b1);
                continue;
            end
            if ($urandom_range(0, 9) == 0)
                t = 6'($urandom);
            else if ($urandom_range(0, 5) == 0 && sym_count > 0 && !parse_halted &&
                     sym_stack[sym_count - 1] == 65)
                t = 6'd18;
            else
                t = good_token();
            send_token(t, 16'($urandom), 1'($urandom_range(0, 60) == 0));
            if (n == 120)
                wait_drained();
        end
        tok.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver
    initial
    begin
        int gap;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold)
                res.ready <= 1'b0;
            else if ($urandom_range(0, 3) == 0)
                res.ready <= 1'b1;
            else if ($urandom_range(0, 19) == 0)
            begin
                gap = $urandom_range(5, 40);
                res.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                res.ready <= 1'b1;
            end
            else
                res.ready <= ($urandom_range(0, 2) != 0);
            @(posedge clk);
        end
    end

    // long hold-off while the sender keeps offering
    initial
    begin
        @(posedge rst_n);
        repeat (600) @(posedge clk);
        rx_hold = 1'b1;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
    end

    // Checker and watchdog
    always @(posedge clk)
    begin
        parse_res_t got;
        parse_res_t want;
        if (rst_n)
        begin
            if ((res.valid && res.ready) || (tok.valid && tok.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (res.valid && res.ready)
            begin
                got = '{res.kind, res.rule_number, res.stack_top_symbol, res.error_line,
                        res.last};
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, got);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got != want)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        errors++;
                    end
                end
            end
            if (idle_cycles > WATCHDOG)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
rtl/core/ll1pp_pkg.sv
rtl/core/ll1pp_if.sv
rtl/core/ll1pp_ram.sv
rtl/core/ll1_predictive_parser_unit.sv
rtl/core/ll1pp_checker.sv
sim/tb_top.sv
